/* src/ifmt_pkg.sv */
`timescale 1ns / 1ps
package ifmt_pkg;

  localparam int unsigned TEXT_MAX = 11;
  localparam int unsigned IDX_W    = $clog2(TEXT_MAX);
  localparam int unsigned CNT_W    = $clog2(TEXT_MAX + 1);

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HEX_A = 8'h57;

  localparam logic [31:0] RECIP10 = 32'hcccccccd;

  typedef struct packed {
    logic [TEXT_MAX-1:0][7:0] chars;
    logic [CNT_W-1:0]         ndig;
    logic                     neg;
    logic [7:0]               fill;
    logic [5:0]               pad;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_HEX_A + {4'd0, d};
    end
    return c;
  endfunction

endpackage

/* src/ifmt_front.sv */
`timescale 1ns / 1ps
module ifmt_front import ifmt_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_kind,
  input  logic        in_zero_fill,
  input  logic [5:0]  in_width,
  input  logic        in_push,
  output logic        in_full,
  output logic        q_push,
  output job_t        q_data,
  input  logic        q_full
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  state_t                   st_r, st_nxt;
  logic [31:0]              mag_r;
  logic                     hex_r;
  logic                     neg_r;
  logic [7:0]               fill_r;
  logic [5:0]               width_r;
  logic [CNT_W-1:0]         ndig_r;
  logic [TEXT_MAX-1:0][7:0] chars_r;

  logic        accept;
  logic [63:0] prod;
  logic [31:0] q_dec;
  logic [31:0] ten_q;
  logic [31:0] rem_dec;
  logic [3:0]  digit;
  logic [31:0] quot;
  logic        conv_done;
  logic [5:0]  width_cl;
  logic [CNT_W-1:0] len;
  logic [5:0]  len6;

  assign in_full = (st_r != S_IDLE);
  assign accept  = in_push & ~in_full;

  always_comb begin
    prod    = {32'd0, mag_r} * {32'd0, RECIP10};
    q_dec   = {3'd0, prod[63:35]};
    ten_q   = {q_dec[28:0], 3'd0} + {q_dec[30:0], 1'b0};
    rem_dec = mag_r - ten_q;
    digit   = hex_r ? mag_r[3:0] : rem_dec[3:0];
    quot    = hex_r ? {4'd0, mag_r[31:4]} : q_dec;
    conv_done = (quot == 32'd0) || (ndig_r + 1'b1 == CNT_W'(TEXT_MAX));
  end

  assign width_cl = ({1'b0, in_width} > MaxW) ? MaxW[5:0] : in_width;

  always_comb begin
    len  = ndig_r + {{(CNT_W-1){1'b0}}, neg_r};
    len6 = 6'(len);
    q_data.chars = chars_r;
    q_data.ndig  = ndig_r;
    q_data.neg   = neg_r;
    q_data.fill  = fill_r;
    q_data.pad   = (width_r > len6) ? (width_r - len6) : 6'd0;
  end

  assign q_push = (st_r == S_PUSH) & ~q_full;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (accept) st_nxt = S_CONV;
      S_CONV: if (conv_done) st_nxt = S_PUSH;
      S_PUSH: if (!q_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hex_r   <= (in_kind == KIND_HEX);
      neg_r   <= (in_kind == KIND_SDEC) && in_value[31];
      mag_r   <= ((in_kind == KIND_SDEC) && in_value[31]) ? (32'd0 - in_value) : in_value;
      fill_r  <= in_zero_fill ? CH_ZERO : CH_SPACE;
      width_r <= width_cl;
      ndig_r  <= '0;
    end else if (st_r == S_CONV) begin
      chars_r[IDX_W'(ndig_r)] <= digit_char(digit);
      ndig_r <= ndig_r + 1'b1;
      mag_r  <= quot;
    end
  end

endmodule

/* src/ifmt_queue.sv */
`timescale 1ns / 1ps
module ifmt_queue import ifmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

/* src/ifmt_back.sv */
`timescale 1ns / 1ps
module ifmt_back import ifmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_empty,
  input  logic       out_pop
);

  logic [5:0]               pad_r;
  logic                     sign_r;
  logic [CNT_W-1:0]         dig_r;
  logic [TEXT_MAX-1:0][7:0] chars_r;
  logic [7:0]               fill_r;
  logic [7:0]               char_r;
  logic                     last_r;
  logic                     ov_r;

  logic [6:0] remain;
  logic       busy;
  logic       emit;
  logic [7:0] ch;

  assign remain = {1'b0, pad_r} + {6'd0, sign_r} + 7'(dig_r);
  assign busy   = (remain != 7'd0);
  assign emit   = busy & (~ov_r | out_pop);
  assign q_pop  = ~busy & ~q_empty;

  always_comb begin
    priority if (pad_r != 6'd0) begin
      ch = fill_r;
    end else if (sign_r) begin
      ch = CH_MINUS;
    end else begin
      ch = chars_r[IDX_W'(dig_r - 1'b1)];
    end
  end

  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_empty = ~ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r  <= 6'd0;
      sign_r <= 1'b0;
      dig_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        pad_r  <= q_data.pad;
        sign_r <= q_data.neg;
        dig_r  <= q_data.ndig;
      end else if (emit) begin
        priority if (pad_r != 6'd0) begin
          pad_r <= pad_r - 6'd1;
        end else if (sign_r) begin
          sign_r <= 1'b0;
        end else begin
          dig_r <= dig_r - 1'b1;
        end
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      chars_r <= q_data.chars;
      fill_r  <= q_data.fill;
    end
    if (emit) begin
      char_r <= ch;
      last_r <= (remain == 7'd1);
    end
  end

endmodule

/* src/integer_field_formatter.sv */
`timescale 1ns / 1ps
// channel   ports                                       request moves when
// input     in_value in_kind in_zero_fill in_width      in_push && !in_full
// result    out_char out_last                           out_pop && !out_empty
//
// The front takes a request, then produces its digits one at a time, lowest first
// (up to ten decimal digits by reciprocal multiply, or eight hex digits by shift),
// and queues the job; in_full stays high after acceptance until the job is queued.
// The back loads a job from a two-entry queue once its last job is sent, then sends
// one character per cycle while out_pop keeps up: fill, sign, then digits, the larger
// of width and text length in all. Reset is synchronous on rst_n and empties both
// sides; stalls on out_pop back up through the queue to in_full.
module integer_field_formatter import ifmt_pkg::*; #(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_kind,
  input  logic        in_zero_fill,
  input  logic [5:0]  in_width,
  input  logic        in_push,
  output logic        in_full,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_empty,
  input  logic        out_pop
);

  job_t f_data, b_data;
  logic f_push, f_full, b_pop, b_empty;

  ifmt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .in_kind      (in_kind),
    .in_zero_fill (in_zero_fill),
    .in_width     (in_width),
    .in_push      (in_push),
    .in_full      (in_full),
    .q_push       (f_push),
    .q_data       (f_data),
    .q_full       (f_full)
  );

  ifmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_data),
    .full      (f_full),
    .pop       (b_pop),
    .pop_data  (b_data),
    .empty     (b_empty)
  );

  ifmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (b_data),
    .q_empty   (b_empty),
    .q_pop     (b_pop),
    .out_char  (out_char),
    .out_last  (out_last),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
